// ===== rtl/ptrs_pkg.sv =====
// Package with the request, result and table entry types of the periodic task ready scheduler.
`default_nettype none

package ptrs_pkg;

  localparam logic [1:0] CMD_CREATE   = 2'd0;
  localparam logic [1:0] CMD_SCHEDULE = 2'd1;
  localparam logic [1:0] CMD_PROCESS  = 2'd2;
  localparam logic [1:0] CMD_INIT     = 2'd3;

  localparam logic [1:0] KIND_CREATED = 2'd0;
  localparam logic [1:0] KIND_FULL    = 2'd1;
  localparam logic [1:0] KIND_INIT    = 2'd2;
  localparam logic [1:0] KIND_RUN     = 2'd3;

  localparam int unsigned CB_INIT  = 0;
  localparam int unsigned CB_PLAIN = 1;
  localparam int unsigned CB_ARGS  = 2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_time;
    logic [31:0] period;
    logic        start_ready;
    logic        has_init;
    logic        has_plain_exec;
    logic        has_args_exec;
  } ptrs_req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] task_id;
    logic [3:0]  slot;
    logic        runs_plain;
    logic        runs_args;
    logic        last_in_run;
  } ptrs_res_t;

  typedef struct packed {
    logic [31:0] task_id;
    logic [31:0] period;
    logic [31:0] stamp;
    logic        ready;
    logic [2:0]  cb_flags;
  } ptrs_entry_t;

endpackage

`default_nettype wire

// ===== rtl/ptrs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ptrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ptrs_alu.sv =====
// Shared adder and unsigned compare used for task ids and due times.
`default_nettype none

module ptrs_alu (
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic [31:0] limit_i,
  output      logic [31:0] sum_o,
  output      logic        lt_o
);

  assign sum_o = a_i + b_i;
  assign lt_o  = (sum_o < limit_i);

endmodule

`default_nettype wire

// ===== rtl/periodic_task_ready_scheduler.sv =====
// Top level of the periodic task ready scheduler with its table sequencer.
`default_nettype none

// A create request registers its result in a pending register, which moves to the output register
// in the flush state. Schedule, process and init requests walk the table from the newest slot down,
// one slot per cycle through the single table RAM read port; a result that cannot move on while the
// output register is full holds the walk. Table entries are not cleared after reset.
module periodic_task_ready_scheduler
  import ptrs_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire ptrs_req_t in_req_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      ptrs_res_t out_res_o
);

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned SW = (IW > 4) ? IW : 4;
  localparam int unsigned EW = $bits(ptrs_entry_t);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [31:0]   now_q, now_d;
  logic          pend_valid_q, pend_valid_d;
  ptrs_res_t     pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  ptrs_res_t     out_q, out_d;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  ptrs_entry_t   ram_wdata, ram_rdata;
  logic [EW-1:0] ram_rbits;

  logic [31:0]   alu_a, alu_b, alu_limit, alu_sum;
  logic          alu_lt;

  logic          slot_free, hit, emit, blocked;
  logic [SW-1:0] idx_ext, cnt_ext;
  ptrs_res_t     new_res;

  ptrs_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  assign ram_rdata = ram_rbits;

  ptrs_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .limit_i (alu_limit),
    .sum_o   (alu_sum),
    .lt_o    (alu_lt)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign idx_ext     = SW'(idx_q);
  assign cnt_ext     = SW'(count_q);

  always_comb begin
    hit  = 1'b0;
    emit = 1'b0;
    new_res = '0;
    new_res.task_id = ram_rdata.task_id;
    new_res.slot    = idx_ext[3:0];
    case (cmd_q)
      CMD_SCHEDULE: begin
        hit = alu_lt;
      end
      CMD_PROCESS: begin
        hit  = ram_rdata.ready;
        emit = 1'b1;
        new_res.result_kind = KIND_RUN;
        new_res.runs_plain  = ram_rdata.cb_flags[CB_PLAIN];
        new_res.runs_args   = ram_rdata.cb_flags[CB_ARGS];
      end
      CMD_INIT: begin
        hit  = ram_rdata.cb_flags[CB_INIT];
        emit = 1'b1;
        new_res.result_kind = KIND_INIT;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    blocked = emit && hit && pend_valid_q && !slot_free;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    cmd_d        = cmd_q;
    now_d        = now_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = idx_q;
    alu_a        = ram_rdata.period;
    alu_b        = ram_rdata.stamp;
    alu_limit    = now_q;

    case (state_q)
      ST_IDLE: begin
        alu_a     = in_req_i.now_time;
        alu_b     = 32'(count_q);
        alu_limit = in_req_i.now_time;
        if (in_valid_i) begin
          cmd_d = in_req_i.cmd;
          now_d = in_req_i.now_time;
          if (in_req_i.cmd == CMD_CREATE) begin
            pend_valid_d = 1'b1;
            pend_d       = '0;
            state_d      = ST_FLUSH;
            if (count_q == CW'(MAX_TASKS)) begin
              pend_d.result_kind = KIND_FULL;
            end else begin
              pend_d.result_kind = KIND_CREATED;
              pend_d.task_id     = alu_sum;
              pend_d.slot        = cnt_ext[3:0];
              ram_we             = 1'b1;
              ram_waddr          = IW'(count_q);
              ram_wdata.task_id  = alu_sum;
              ram_wdata.period   = in_req_i.period;
              ram_wdata.stamp    = in_req_i.now_time;
              ram_wdata.ready    = in_req_i.start_ready;
              ram_wdata.cb_flags = {in_req_i.has_args_exec, in_req_i.has_plain_exec,
                                    in_req_i.has_init};
              count_d            = count_q + CW'(1);
            end
          end else if (count_q != '0) begin
            ram_re    = 1'b1;
            ram_raddr = IW'(count_q - CW'(1));
            idx_d     = IW'(count_q - CW'(1));
            state_d   = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (!blocked) begin
          if (hit) begin
            if (cmd_q == CMD_SCHEDULE) begin
              ram_we          = 1'b1;
              ram_wdata.stamp = now_q;
              ram_wdata.ready = 1'b1;
            end else if (cmd_q == CMD_PROCESS) begin
              ram_we          = 1'b1;
              ram_wdata.ready = 1'b0;
            end
            if (emit) begin
              if (pend_valid_q) begin
                out_d       = pend_q;
                out_valid_d = 1'b1;
              end
              pend_d       = new_res;
              pend_valid_d = 1'b1;
            end
          end
          if (idx_q == '0) begin
            state_d = ST_FLUSH;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q - IW'(1);
            idx_d     = idx_q - IW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          out_d             = pend_q;
          out_d.last_in_run = 1'b1;
          out_valid_d       = 1'b1;
          pend_valid_d      = 1'b0;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cmd_q  <= cmd_d;
    now_q  <= now_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

// ===== bench/periodic_task_ready_scheduler_test.sv =====
// Self-checking testbench for the periodic task ready scheduler, with its own table predictor.
`timescale 1ns / 100ps

module periodic_task_ready_scheduler_test;
  import ptrs_pkg::*;

  localparam int unsigned TABLE_DEPTH     = 16;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 250;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  ptrs_req_t in_req    = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  ptrs_res_t out_res;

  ptrs_entry_t task_entries [TABLE_DEPTH];
  int unsigned task_total = 0;
  ptrs_res_t   pending_results [$];
  ptrs_res_t   oldest_result;
  logic [31:0] tick_now = 32'h0000_0100;

  int unsigned failures      = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned hold_off_left = 0;
  int unsigned stall_left    = 0;
  bit          idle_enable   = 1'b1;

  periodic_task_ready_scheduler #(
    .MAX_TASKS(TABLE_DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_res_o  (out_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic ptrs_req_t build_request(logic [1:0] cmd, logic [31:0] now_time,
                                              logic [31:0] period, logic start_ready,
                                              logic [2:0] callbacks);
    ptrs_req_t req;
    req.cmd            = cmd;
    req.now_time       = now_time;
    req.period         = period;
    req.start_ready    = start_ready;
    req.has_init       = callbacks[CB_INIT];
    req.has_plain_exec = callbacks[CB_PLAIN];
    req.has_args_exec  = callbacks[CB_ARGS];
    return req;
  endfunction

  function automatic void predict_request(ptrs_req_t req);
    ptrs_res_t   res;
    logic [31:0] due;
    int unsigned first;
    first = pending_results.size();
    res = '0;
    case (req.cmd)
      CMD_CREATE: begin
        if (task_total >= TABLE_DEPTH) begin
          res.result_kind = KIND_FULL;
        end else begin
          task_entries[task_total].task_id           = req.now_time + 32'(task_total);
          task_entries[task_total].period            = req.period;
          task_entries[task_total].stamp             = req.now_time;
          task_entries[task_total].ready             = req.start_ready;
          task_entries[task_total].cb_flags[CB_INIT]  = req.has_init;
          task_entries[task_total].cb_flags[CB_PLAIN] = req.has_plain_exec;
          task_entries[task_total].cb_flags[CB_ARGS]  = req.has_args_exec;
          res.result_kind = KIND_CREATED;
          res.task_id     = task_entries[task_total].task_id;
          res.slot        = 4'(task_total);
          task_total++;
        end
        pending_results.push_back(res);
      end
      CMD_SCHEDULE: begin
        for (int s = 0; s < int'(task_total); s++) begin
          due = task_entries[s].period + task_entries[s].stamp;
          if (due < req.now_time) begin
            task_entries[s].stamp = req.now_time;
            task_entries[s].ready = 1'b1;
          end
        end
      end
      CMD_PROCESS: begin
        for (int s = int'(task_total) - 1; s >= 0; s--) begin
          if (task_entries[s].ready) begin
            res.result_kind = KIND_RUN;
            res.task_id     = task_entries[s].task_id;
            res.slot        = 4'(s);
            res.runs_plain  = task_entries[s].cb_flags[CB_PLAIN];
            res.runs_args   = task_entries[s].cb_flags[CB_ARGS];
            pending_results.push_back(res);
            task_entries[s].ready = 1'b0;
          end
        end
      end
      default: begin
        for (int s = int'(task_total) - 1; s >= 0; s--) begin
          if (task_entries[s].cb_flags[CB_INIT]) begin
            res.result_kind = KIND_INIT;
            res.task_id     = task_entries[s].task_id;
            res.slot        = 4'(s);
            pending_results.push_back(res);
          end
        end
      end
    endcase
    if (pending_results.size() > first) begin
      pending_results[pending_results.size() - 1].last_in_run = 1'b1;
    end
  endfunction

  function automatic ptrs_req_t random_request(int unsigned create_weight);
    int unsigned pick;
    logic [1:0]  cmd;
    logic [31:0] period;
    logic [31:0] stamp_time;
    pick = $urandom_range(0, 99);
    if (pick < create_weight) begin
      cmd = CMD_CREATE;
    end else if (pick < create_weight + 35) begin
      cmd = CMD_SCHEDULE;
    end else if (pick < create_weight + 70) begin
      cmd = CMD_PROCESS;
    end else begin
      cmd = CMD_INIT;
    end
    if ($urandom_range(0, 15) == 0) begin
      tick_now = $urandom();
    end else begin
      tick_now = tick_now + $urandom_range(0, 40);
    end
    period = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 120);
    stamp_time = (cmd == CMD_PROCESS || cmd == CMD_INIT) ? $urandom() : tick_now;
    return build_request(cmd, stamp_time, period, 1'($urandom_range(0, 1)),
                         3'($urandom_range(0, 7)));
  endfunction

  task automatic send_request(input ptrs_req_t req);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(req);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (failures < 10) begin
          $display("Unexpected result: kind %0d id %h slot %0d plain %b args %b last %b",
                   out_res.result_kind, out_res.task_id, out_res.slot, out_res.runs_plain,
                   out_res.runs_args, out_res.last_in_run);
        end
        failures++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_res.result_kind !== oldest_result.result_kind ||
            out_res.task_id !== oldest_result.task_id ||
            out_res.slot !== oldest_result.slot ||
            out_res.runs_plain !== oldest_result.runs_plain ||
            out_res.runs_args !== oldest_result.runs_args ||
            out_res.last_in_run !== oldest_result.last_in_run) begin
          if (failures < 10) begin
            $display("Mismatch: expected kind %0d id %h slot %0d plain %b args %b last %b",
                     oldest_result.result_kind, oldest_result.task_id, oldest_result.slot,
                     oldest_result.runs_plain, oldest_result.runs_args,
                     oldest_result.last_in_run);
            $display("          actual   kind %0d id %h slot %0d plain %b args %b last %b",
                     out_res.result_kind, out_res.task_id, out_res.slot, out_res.runs_plain,
                     out_res.runs_args, out_res.last_in_run);
          end
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("periodic_task_ready_scheduler test failed");
    $finish;
  end

  task automatic test_empty_table();
    send_request(build_request(CMD_SCHEDULE, 32'hFFFF_FFFF, '0, 1'b0, 3'b000));
    send_request(build_request(CMD_PROCESS, 32'h0, '0, 1'b0, 3'b000));
    send_request(build_request(CMD_INIT, 32'h0, '0, 1'b0, 3'b000));
  endtask

  task automatic test_create_extremes();
    send_request(build_request(CMD_CREATE, 32'h0000_0000, 32'h0000_0000, 1'b0, 3'b001));
    send_request(build_request(CMD_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 3'b111));
    send_request(build_request(CMD_CREATE, 32'hFFFF_FFF0, 32'h0000_0020, 1'b0, 3'b010));
    send_request(build_request(CMD_CREATE, 32'h0000_1000, 32'h0000_0005, 1'b0, 3'b100));
    send_request(build_request(CMD_CREATE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 3'b000));
  endtask

  // A task is due only when its wrapped deadline lies strictly below the current time.
  task automatic test_due_comparison();
    send_request(build_request(CMD_SCHEDULE, 32'h0000_0011, '0, 1'b0, 3'b000));
    send_request(build_request(CMD_PROCESS, 32'hA5A5_A5A5, '1, 1'b1, 3'b111));
    send_request(build_request(CMD_PROCESS, 32'h5A5A_5A5A, '0, 1'b0, 3'b000));
    send_request(build_request(CMD_SCHEDULE, 32'h0000_1005, '0, 1'b0, 3'b000));
    send_request(build_request(CMD_SCHEDULE, 32'h0000_1006, '0, 1'b0, 3'b000));
    send_request(build_request(CMD_PROCESS, 32'h0, '0, 1'b0, 3'b000));
    send_request(build_request(CMD_SCHEDULE, 32'hFFFF_FFFF, '0, 1'b0, 3'b000));
    send_request(build_request(CMD_PROCESS, 32'h0, '0, 1'b0, 3'b000));
  endtask

  task automatic test_init_calls();
    send_request(build_request(CMD_INIT, 32'hFFFF_FFFF, '1, 1'b1, 3'b111));
  endtask

  task automatic test_random_traffic(int unsigned count, int unsigned create_weight);
    repeat (count) send_request(random_request(create_weight));
  endtask

  task automatic test_table_full();
    while (task_total < TABLE_DEPTH) begin
      send_request(build_request(CMD_CREATE, tick_now, $urandom_range(0, 120),
                                 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7))));
    end
    repeat (2) begin
      send_request(build_request(CMD_CREATE, $urandom(), $urandom(), 1'b1, 3'b111));
    end
  endtask

  // The receiver holds off while requests keep coming, so the block must stall its input.
  task automatic test_output_backpressure();
    hold_off_left = HOLD_OFF_CYCLES;
    test_random_traffic(30, 5);
  endtask

  task automatic test_sender_pause();
    wait_for_drain();
    test_random_traffic(10, 5);
  endtask

  task automatic test_quiet_traffic();
    idle_enable = 1'b0;
    test_random_traffic(40, 5);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_create_extremes();
    test_due_comparison();
    test_init_calls();
    test_random_traffic(140, 10);
    test_table_full();
    test_output_backpressure();
    test_sender_pause();
    test_quiet_traffic();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      failures++;
    end
    if (failures == 0) begin
      $display("periodic_task_ready_scheduler test passed");
    end else begin
      $display("periodic_task_ready_scheduler test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ptrs_pkg.sv
rtl/ptrs_ram.sv
rtl/ptrs_alu.sv
rtl/periodic_task_ready_scheduler.sv
bench/periodic_task_ready_scheduler_test.sv
